// ===== rtl/core/mcw_pkg.sv =====
// ----------------------------------------------------------------------------
// mcw_pkg: shared types and constants
// Request opcodes, the command word passed from the front end to the back end,
// and fixed field widths of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

package mcw_pkg;

  // request opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_TARGET = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam int SYM_BITS    = 8;
  localparam int SYM_VALUES  = 256;
  localparam int OUT_BEGIN_W = 12;
  localparam int OUT_LEN_W   = 13;
  localparam int CMDQ_DEPTH  = 2;

  typedef struct packed {
    logic [1:0]          op;
    logic [SYM_BITS-1:0] sym;   // already folded into the alphabet
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_head_t;

endpackage

`default_nettype wire

// ===== rtl/core/minimum_covering_window.sv =====
// ----------------------------------------------------------------------------
// minimum_covering_window: shortest text window covering a target multiset
// Streams target and text bytes, reports the earliest shortest window.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on in_push/in_full with in_operation (clear, target byte,
//    text byte, finish) and in_symbol. A two-entry request queue sits in
//    front of the window engine, so pushes keep landing while it works.
//  - Results leave on out_empty/out_pop; only finish produces one: found,
//    window_begin, window_length (zero when not found) and overflow.
//  - Target bytes pass through ST_TGT, text bytes through ST_TXT, ST_CHK
//    and ST_SH_TXT/ST_SH_NEED per byte dropped off the window's left edge;
//    each byte leaves at most once. No request is taken until the engine
//    is back in idle; the pace is set by the need table read-modify-write,
//    a single memory with registered read. Clear and finish are handled in
//    idle; a finish moves from the queue head into the result register,
//    lowering out_empty, once the engine is idle and the register is free.
//  - Reset (rst_n low, synchronous) empties both queues and the window
//    state; the need table reads as zero through per-symbol valid bits, so
//    no clearing pass is needed. Clear does the same, but for the queues.
//  - If a result is not popped, a further finish waits in the request queue
//    and in_full rises once it fills; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module minimum_covering_window #(
  parameter int TEXT_DEPTH    = 4096,
  parameter int ALPHABET_SIZE = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request side
  input  wire logic                               in_push,
  output logic                                    in_full,
  input  wire logic [1:0]                         in_operation,
  input  wire logic [mcw_pkg::SYM_BITS-1:0]       in_symbol,
  // result side
  output logic                                    out_empty,
  input  wire logic                               out_pop,
  output logic                                    out_found,
  output logic [mcw_pkg::OUT_BEGIN_W-1:0]         out_window_begin,
  output logic [mcw_pkg::OUT_LEN_W-1:0]           out_window_length,
  output logic                                    out_overflow
);

  mcw_pkg::cmdq_head_t head;
  logic                head_pop;

  // front end: fold symbol, queue request
  mcw_front #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_symbol    (in_symbol),
    .head         (head),
    .head_pop     (head_pop)
  );

  // back end: window engine and result register
  mcw_back #(
    .TEXT_DEPTH    (TEXT_DEPTH),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .head_pop          (head_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_found         (out_found),
    .out_window_begin  (out_window_begin),
    .out_window_length (out_window_length),
    .out_overflow      (out_overflow)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mcw_ram.sv =====
// ----------------------------------------------------------------------------
// mcw_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mcw_front.sv =====
// ----------------------------------------------------------------------------
// mcw_front: request intake
// Folds the symbol into the alphabet and queues requests for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mcw_front #(
  parameter int ALPHABET_SIZE = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic [1:0]                   in_operation,
  input  wire logic [mcw_pkg::SYM_BITS-1:0] in_symbol,
  output mcw_pkg::cmdq_head_t               head,
  input  wire logic                         head_pop
);

  localparam int TBL_W  = mcw_pkg::SYM_VALUES * mcw_pkg::SYM_BITS;
  localparam int PTR_W  = $clog2(mcw_pkg::CMDQ_DEPTH);
  localparam int CNT_W  = $clog2(mcw_pkg::CMDQ_DEPTH + 1);

  function automatic logic [TBL_W-1:0] build_fold();
    logic [TBL_W-1:0] t;
    t = '0;
    for (int i = 0; i < mcw_pkg::SYM_VALUES; i++) begin
      t[i*mcw_pkg::SYM_BITS +: mcw_pkg::SYM_BITS] = mcw_pkg::SYM_BITS'(i % ALPHABET_SIZE);
    end
    return t;
  endfunction

  localparam logic [TBL_W-1:0] FOLD_TBL = build_fold();

  mcw_pkg::cmd_t    q_r [mcw_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;
  mcw_pkg::cmd_t    new_cmd;

  assign in_full    = (cnt_r == CNT_W'(mcw_pkg::CMDQ_DEPTH));
  assign do_wr      = in_push && !in_full;
  assign do_rd      = head_pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_r[rptr_r];

  always_comb begin
    new_cmd.op  = in_operation;
    new_cmd.sym = FOLD_TBL[in_symbol*mcw_pkg::SYM_BITS +: mcw_pkg::SYM_BITS];
  end

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PTR_W'(mcw_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PTR_W'(mcw_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mcw_back.sv =====
// ----------------------------------------------------------------------------
// mcw_back: window engine
// Sequencer that updates the need table and text store, shrinks the window
// and holds the best window and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcw_back #(
  parameter int TEXT_DEPTH    = 4096,
  parameter int ALPHABET_SIZE = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mcw_pkg::cmdq_head_t             head,
  output logic                                 head_pop,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic                                 out_found,
  output logic [mcw_pkg::OUT_BEGIN_W-1:0]      out_window_begin,
  output logic [mcw_pkg::OUT_LEN_W-1:0]        out_window_length,
  output logic                                 out_overflow
);

  localparam int SYM_W  = $clog2(ALPHABET_SIZE);
  localparam int IDX_W  = $clog2(TEXT_DEPTH);
  localparam int CNT_W  = $clog2(TEXT_DEPTH + 2);
  localparam int NEED_W = CNT_W + 1;

  localparam logic [CNT_W-1:0]         DEPTH_C    = CNT_W'(TEXT_DEPTH);
  localparam logic [CNT_W-1:0]         TARGET_CAP = CNT_W'(TEXT_DEPTH + 1);
  localparam logic signed [NEED_W-1:0] NEED_ONE   = NEED_W'(1);
  localparam logic signed [NEED_W-1:0] NEED_ZERO  = '0;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_TGT     = 3'd1;
  localparam logic [2:0] ST_TXT     = 3'd2;
  localparam logic [2:0] ST_CHK     = 3'd3;
  localparam logic [2:0] ST_SH_TXT  = 3'd4;
  localparam logic [2:0] ST_SH_NEED = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         target_r, target_nxt;
  logic [CNT_W-1:0]         matched_r, matched_nxt;
  logic [CNT_W-1:0]         left_r, left_nxt;
  logic [CNT_W-1:0]         tcnt_r, tcnt_nxt;
  logic [CNT_W-1:0]         best_len_r, best_len_nxt;
  logic [IDX_W-1:0]         best_beg_r, best_beg_nxt;
  logic                     best_vld_r, best_vld_nxt;
  logic                     dropped_r, dropped_nxt;
  logic [SYM_W-1:0]         cur_sym_r, cur_sym_nxt;
  logic [ALPHABET_SIZE-1:0] nvld_r, nvld_nxt;
  logic                     rd_vld_r;

  logic                     out_vld_r, out_vld_nxt;
  logic                     out_found_r, out_found_nxt;
  logic [mcw_pkg::OUT_BEGIN_W-1:0] out_beg_r, out_beg_nxt;
  logic [mcw_pkg::OUT_LEN_W-1:0]   out_len_r, out_len_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  // need table port
  logic                     need_we;
  logic [SYM_W-1:0]         need_raddr;
  logic [NEED_W-1:0]        need_wdata;
  logic [NEED_W-1:0]        need_rdata;
  logic signed [NEED_W-1:0] need_cur;
  logic signed [NEED_W-1:0] need_inc;
  logic signed [NEED_W-1:0] need_dec;

  // text store port
  logic                     txt_we;
  logic [SYM_W-1:0]         txt_rdata;

  logic [CNT_W-1:0]         win_len;
  logic [31:0]              beg_ext;
  logic [31:0]              len_ext;

  mcw_ram #(.WIDTH(NEED_W), .DEPTH(ALPHABET_SIZE)) u_need (
    .clk   (clk),
    .we    (need_we),
    .waddr (cur_sym_r),
    .wdata (need_wdata),
    .raddr (need_raddr),
    .rdata (need_rdata)
  );

  mcw_ram #(.WIDTH(SYM_W), .DEPTH(TEXT_DEPTH)) u_text (
    .clk   (clk),
    .we    (txt_we),
    .waddr (tcnt_r[IDX_W-1:0]),
    .wdata (head.cmd.sym[SYM_W-1:0]),
    .raddr (left_r[IDX_W-1:0]),
    .rdata (txt_rdata)
  );

  // entries not written since the last clear read as zero
  assign need_cur = rd_vld_r ? signed'(need_rdata) : NEED_ZERO;
  assign need_inc = need_cur + NEED_ONE;
  assign need_dec = need_cur - NEED_ONE;
  assign win_len  = tcnt_r - left_r;
  assign beg_ext  = 32'(best_beg_r);
  assign len_ext  = 32'(best_len_r);

  assign out_empty         = !out_vld_r;
  assign out_found         = out_found_r;
  assign out_window_begin  = out_beg_r;
  assign out_window_length = out_len_r;
  assign out_overflow      = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    matched_nxt   = matched_r;
    left_nxt      = left_r;
    tcnt_nxt      = tcnt_r;
    best_len_nxt  = best_len_r;
    best_beg_nxt  = best_beg_r;
    best_vld_nxt  = best_vld_r;
    dropped_nxt   = dropped_r;
    cur_sym_nxt   = cur_sym_r;
    nvld_nxt      = nvld_r;
    out_vld_nxt   = out_vld_r && !out_pop;
    out_found_nxt = out_found_r;
    out_beg_nxt   = out_beg_r;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;
    head_pop      = 1'b0;
    need_we       = 1'b0;
    need_wdata    = need_inc;
    need_raddr    = head.cmd.sym[SYM_W-1:0];
    txt_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          case (head.cmd.op)
            mcw_pkg::OP_CLEAR: begin
              head_pop     = 1'b1;
              target_nxt   = '0;
              matched_nxt  = '0;
              left_nxt     = '0;
              tcnt_nxt     = '0;
              best_len_nxt = '0;
              best_beg_nxt = '0;
              best_vld_nxt = 1'b0;
              dropped_nxt  = 1'b0;
              nvld_nxt     = '0;
            end
            mcw_pkg::OP_TARGET: begin
              head_pop = 1'b1;
              if (tcnt_r == '0 && !dropped_r && target_r < TARGET_CAP) begin
                cur_sym_nxt = head.cmd.sym[SYM_W-1:0];
                state_nxt   = ST_TGT;
              end
            end
            mcw_pkg::OP_TEXT: begin
              head_pop = 1'b1;
              if (tcnt_r >= DEPTH_C) begin
                dropped_nxt = 1'b1;
              end else begin
                txt_we      = 1'b1;
                cur_sym_nxt = head.cmd.sym[SYM_W-1:0];
                state_nxt   = ST_TXT;
              end
            end
            mcw_pkg::OP_FINISH: begin
              if (!out_vld_r || out_pop) begin
                head_pop      = 1'b1;
                out_vld_nxt   = 1'b1;
                out_found_nxt = best_vld_r;
                out_beg_nxt   = best_vld_r ? beg_ext[mcw_pkg::OUT_BEGIN_W-1:0] : '0;
                out_len_nxt   = best_vld_r ? len_ext[mcw_pkg::OUT_LEN_W-1:0] : '0;
                out_ovf_nxt   = dropped_r;
              end
            end
            default: begin
              head_pop = 1'b1;
            end
          endcase
        end
      end
      ST_TGT: begin
        need_we              = 1'b1;
        need_wdata           = need_inc;
        nvld_nxt[cur_sym_r]  = 1'b1;
        target_nxt           = target_r + CNT_W'(1);
        state_nxt            = ST_IDLE;
      end
      ST_TXT: begin
        need_we              = 1'b1;
        need_wdata           = need_dec;
        nvld_nxt[cur_sym_r]  = 1'b1;
        if (need_cur > NEED_ZERO) begin
          matched_nxt = matched_r + CNT_W'(1);
        end
        tcnt_nxt  = tcnt_r + CNT_W'(1);
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // window covers the target and is not empty: record it if first or shorter,
        // then drop the leftmost byte; text store read of left edge is in flight
        if (target_r != '0 && matched_r == target_r && left_r < tcnt_r) begin
          if (!best_vld_r || win_len < best_len_r) begin
            best_vld_nxt = 1'b1;
            best_len_nxt = win_len;
            best_beg_nxt = left_r[IDX_W-1:0];
          end
          state_nxt = ST_SH_TXT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SH_TXT: begin
        need_raddr  = txt_rdata;
        cur_sym_nxt = txt_rdata;
        state_nxt   = ST_SH_NEED;
      end
      ST_SH_NEED: begin
        need_we              = 1'b1;
        need_wdata           = need_inc;
        nvld_nxt[cur_sym_r]  = 1'b1;
        if (need_inc > NEED_ZERO) begin
          matched_nxt = matched_r - CNT_W'(1);
        end
        left_nxt  = left_r + CNT_W'(1);
        state_nxt = ST_CHK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      target_r   <= '0;
      matched_r  <= '0;
      left_r     <= '0;
      tcnt_r     <= '0;
      best_len_r <= '0;
      best_beg_r <= '0;
      best_vld_r <= 1'b0;
      dropped_r  <= 1'b0;
      nvld_r     <= '0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      target_r   <= target_nxt;
      matched_r  <= matched_nxt;
      left_r     <= left_nxt;
      tcnt_r     <= tcnt_nxt;
      best_len_r <= best_len_nxt;
      best_beg_r <= best_beg_nxt;
      best_vld_r <= best_vld_nxt;
      dropped_r  <= dropped_nxt;
      nvld_r     <= nvld_nxt;
      rd_vld_r   <= nvld_r[need_raddr];
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_sym_r   <= cur_sym_nxt;
    out_found_r <= out_found_nxt;
    out_beg_r   <= out_beg_nxt;
    out_len_r   <= out_len_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

endmodule

`default_nettype wire

// ===== verif/minimum_covering_window_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// minimum_covering_window_tb: self-checking bench for the covering window
// Drives clear/target/text/finish requests through the push/full queue and
// pops reports with random stalls on both sides. A behavioral window search
// predicts each report not typed in the short stimulus table that opens the
// run. Randomized target/text cases with some pure noise make up the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module minimum_covering_window_tb;

  localparam int TEXT_DEPTH   = 4096;
  localparam int TARGET_LIMIT = TEXT_DEPTH + 1;  // target symbols past this are ignored
  localparam int RANDOM_ITEMS = 1275;
  localparam int IDLE_PCT     = 27;

  // one finish report, laid out like the result ports
  typedef struct packed {
    logic        found;
    logic [11:0] start;
    logic [12:0] length;
    logic        ovf;
  } report_t;

  localparam report_t NO_WINDOW = '{found: 1'b0, start: 12'd0, length: 13'd0, ovf: 1'b0};

  // one row of the opening stimulus table; typed rows carry their own answer
  typedef struct {
    logic [1:0] op;
    logic [7:0] sym;
    bit         typed;
    report_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_operation = mcw_pkg::OP_CLEAR;
  logic [7:0]  in_symbol = 8'h00;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_found;
  logic [11:0] out_window_begin;
  logic [12:0] out_window_length;
  logic        out_overflow;

  minimum_covering_window #(
    .TEXT_DEPTH   (TEXT_DEPTH),
    .ALPHABET_SIZE(mcw_pkg::SYM_VALUES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_operation     (in_operation),
    .in_symbol        (in_symbol),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_found        (out_found),
    .out_window_begin (out_window_begin),
    .out_window_length(out_window_length),
    .out_overflow     (out_overflow)
  );

  // --------------------------------------------------------------------------
  // Window search predictor
  // need_cnt goes negative for surplus symbols inside the window; hit_total
  // counts target symbols currently satisfied, so the window covers the
  // target exactly when hit_total == tgt_total.
  // --------------------------------------------------------------------------
  int          need_cnt [mcw_pkg::SYM_VALUES];
  logic [7:0]  text_mem [TEXT_DEPTH];
  int unsigned tgt_total, hit_total, win_left, text_len, best_len, best_pos;
  bit          best_ok, text_dropped;

  function automatic void window_clear();
    foreach (need_cnt[i]) need_cnt[i] = 0;
    tgt_total    = 0;
    hit_total    = 0;
    win_left     = 0;
    text_len     = 0;
    best_len     = 0;
    best_pos     = 0;
    best_ok      = 1'b0;
    text_dropped = 1'b0;
  endfunction

  // Applies one request; returns 1 with the report when it is a finish.
  function automatic bit window_predict(input logic [1:0] op, input logic [7:0] sym,
                                        output report_t rpt);
    int unsigned right, span;
    logic [7:0]  gone;
    rpt = NO_WINDOW;
    case (op)
      mcw_pkg::OP_CLEAR: begin
        window_clear();
        return 1'b0;
      end
      mcw_pkg::OP_TARGET: begin
        // targets only count before any text and up to the cap
        if (text_len == 0 && !text_dropped && tgt_total < TARGET_LIMIT) begin
          need_cnt[sym]++;
          tgt_total++;
        end
        return 1'b0;
      end
      mcw_pkg::OP_TEXT: begin
        if (text_len >= TEXT_DEPTH) begin
          text_dropped = 1'b1;
          return 1'b0;
        end
        right = text_len;
        text_mem[right] = sym;
        text_len++;
        if (need_cnt[sym] > 0) hit_total++;
        need_cnt[sym]--;
        // shrink from the left while covering; strict < keeps the earliest
        while (tgt_total > 0 && hit_total == tgt_total && win_left <= right) begin
          span = right - win_left + 1;
          if (!best_ok || span < best_len) begin
            best_ok  = 1'b1;
            best_len = span;
            best_pos = win_left;
          end
          gone = text_mem[win_left];
          need_cnt[gone]++;
          if (need_cnt[gone] > 0) hit_total--;
          win_left++;
        end
        return 1'b0;
      end
      default: begin
        rpt.found  = best_ok;
        rpt.start  = best_ok ? best_pos[11:0] : 12'd0;
        rpt.length = best_ok ? best_len[12:0] : 13'd0;
        rpt.ovf    = text_dropped;
        return 1'b1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  report_t     pending_reports [$];  // reports owed by accepted finish requests
  int unsigned errors = 0;
  int unsigned req_count = 0;        // accepted requests
  int unsigned reports_seen = 0;
  bit          steady_flow = 1'b0;   // when set neither side idles

  // 100 MHz clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driver. Idle gaps come first so in_push is never lowered and
  // raised in the same step. in_full is read right after the edge, i.e. the
  // value the block saw at that edge.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] op, input logic [7:0] sym,
                              input bit use_typed = 1'b0,
                              input report_t typed_rpt = NO_WINDOW);
    int unsigned gap;
    report_t     rpt;
    gap = 0;
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_operation <= op;
    in_symbol    <= sym;
    do @(posedge clk); while (in_full);
    req_count++;
    if (window_predict(op, sym, rpt))
      pending_reports.push_back(use_typed ? typed_rpt : rpt);
  endtask

  // --------------------------------------------------------------------------
  // Report checker: pops with random stalls, compares against the oldest owed
  // report field by field.
  // --------------------------------------------------------------------------
  initial begin
    report_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          errors++;
          $error("report popped with no finish request outstanding");
        end else begin
          want = pending_reports.pop_front();
          if (out_found !== want.found) begin
            errors++;
            $error("found: expected %0d, got %0d", want.found, out_found);
          end
          if (out_window_begin !== want.start) begin
            errors++;
            $error("window_begin: expected %0d, got %0d", want.start, out_window_begin);
          end
          if (out_window_length !== want.length) begin
            errors++;
            $error("window_length: expected %0d, got %0d", want.length, out_window_length);
          end
          if (out_overflow !== want.ovf) begin
            errors++;
            $error("overflow: expected %0d, got %0d", want.ovf, out_overflow);
          end
        end
      end
      out_pop <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // One well-formed case: clear, a target drawn from a small pool, text that
  // mostly reuses the pool so windows actually close, then finish. A few
  // mid-text finishes and late target bytes (ignored after text) are mixed in.
  task automatic random_window_case();
    logic [7:0]  pool [4];
    int unsigned pool_n, n_tgt, n_txt, pick;
    pool_n = $urandom_range(1, 4);
    foreach (pool[i]) pool[i] = 8'($urandom_range(255));
    send_request(mcw_pkg::OP_CLEAR, 8'($urandom_range(255)));
    n_tgt = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
    repeat (n_tgt) send_request(mcw_pkg::OP_TARGET, pool[$urandom_range(pool_n - 1)]);
    n_txt = $urandom_range(0, 30);
    repeat (n_txt) begin
      pick = $urandom_range(99);
      if (pick < 4)
        send_request(mcw_pkg::OP_FINISH, 8'($urandom_range(255)));
      else if (pick < 7)
        send_request(mcw_pkg::OP_TARGET, 8'($urandom_range(255)));
      else if (pick < 85)
        send_request(mcw_pkg::OP_TEXT, pool[$urandom_range(pool_n - 1)]);
      else
        send_request(mcw_pkg::OP_TEXT, 8'($urandom_range(255)));
    end
    send_request(mcw_pkg::OP_FINISH, 8'($urandom_range(255)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t   directed_rows [25];
    int unsigned rand_start;

    directed_rows = '{
      // finish straight out of reset: nothing found
      '{mcw_pkg::OP_FINISH, 8'h00, 1'b1, NO_WINDOW},
      // target {00, FF, FF}: extremes and a repeated symbol
      '{mcw_pkg::OP_TARGET, 8'h00, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_TARGET, 8'hFF, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_TARGET, 8'hFF, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_TEXT,   8'h12, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_TEXT,   8'hFF, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_TEXT,   8'h00, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_TEXT,   8'h34, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_TEXT,   8'hFF, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_FINISH, 8'h5C, 1'b0, NO_WINDOW},
      // text continues after finish and a shorter window shows up
      '{mcw_pkg::OP_TEXT,   8'h00, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_TEXT,   8'hFF, 1'b0, NO_WINDOW},
      // target byte after text is ignored
      '{mcw_pkg::OP_TARGET, 8'h55, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_FINISH, 8'hFF, 1'b0, NO_WINDOW},
      // clear wipes everything
      '{mcw_pkg::OP_CLEAR,  8'hA5, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_FINISH, 8'h00, 1'b1, NO_WINDOW},
      // empty target never reports a window
      '{mcw_pkg::OP_TEXT,   8'h01, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_TEXT,   8'h02, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_FINISH, 8'h00, 1'b1, NO_WINDOW},
      '{mcw_pkg::OP_TARGET, 8'h80, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_FINISH, 8'h00, 1'b1, NO_WINDOW},
      // single-symbol target hit by the first text byte
      '{mcw_pkg::OP_CLEAR,  8'h00, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_TARGET, 8'h7F, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_TEXT,   8'h7F, 1'b0, NO_WINDOW},
      '{mcw_pkg::OP_FINISH, 8'h00, 1'b1,
        '{found: 1'b1, start: 12'd0, length: 13'd1, ovf: 1'b0}}
    };

    window_clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].sym,
                   directed_rows[i].typed, directed_rows[i].want);

    // Random part: mostly well-formed cases, some raw noise. A stretch in
    // the middle runs with no idling on either side.
    rand_start = req_count;
    while (req_count - rand_start < RANDOM_ITEMS) begin
      steady_flow = (req_count - rand_start >= 400) && (req_count - rand_start < 700);
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(3, 12))
          send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
      else
        random_window_case();
    end
    steady_flow = 1'b0;
    in_push <= 1'b0;

    // drain, then give any stray report time to show up
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d requests and %0d checked reports", req_count, reports_seen);
    $display("incl. extreme symbols, late and empty targets, mid-text finishes, noise");
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/mcw_pkg.sv
rtl/core/mcw_ram.sv
rtl/core/mcw_front.sv
rtl/core/mcw_back.sv
rtl/core/minimum_covering_window.sv
verif/minimum_covering_window_tb.sv
